// File: rtl/cqi_pkg.sv
// ----------------------------------------------------------------------------
// cqi_pkg: shared types and codes for the circular queue with iterator
// Operation and status codes, payload structs and the controller command.
// ----------------------------------------------------------------------------
package cqi_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned STEP_W    = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes
	localparam logic [1:0] OP_PUSH      = 2'd0;
	localparam logic [1:0] OP_POP       = 2'd1;
	localparam logic [1:0] OP_ITER_RST  = 2'd2;
	localparam logic [1:0] OP_ITER_READ = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_OUT_RANGE = 2'd3;

	// Configuration register index
	localparam logic [0:0] REG_CAPACITY = 1'd0;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] push_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic [1:0]         status;
		logic [4:0]         occupancy;
		logic               iter_in_range;
	} result_t;

	typedef struct packed {
		logic capture;  // latch the operation and read the store
		logic execute;  // update pointers and register the result
	} dp_cmd_t;

endpackage

// File: rtl/cqi_ctrl.sv
// ----------------------------------------------------------------------------
// cqi_ctrl: operation sequencer
// Two-state machine: accept an operation, then execute it and strobe done.
// ----------------------------------------------------------------------------
module cqi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output cqi_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd.capture = start && (state_q == S_IDLE);
		cmd.execute = (state_q == S_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: rtl/cqi_dp.sv
// ----------------------------------------------------------------------------
// cqi_dp: queue datapath
// Ring store, head/tail/iterator pointers, word count and result register.
// ----------------------------------------------------------------------------
module cqi_dp #(
	parameter int unsigned DEPTH = cqi_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cqi_pkg::dp_cmd_t             cmd,
	input  cqi_pkg::item_t               item,
	input  logic [cqi_pkg::CAP_W-1:0]    capacity,
	output cqi_pkg::result_t             result
);

	localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CAP_W  = cqi_pkg::CAP_W;
	localparam int unsigned STEP_W = cqi_pkg::STEP_W;
	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

	logic [31:0]       mem [DEPTH];

	logic [1:0]        op_q;
	logic [31:0]       val_q;
	logic [31:0]       rd_data_q;
	logic [IDX_W-1:0]  head_q, tail_q, iter_pos_q;
	logic [CAP_W-1:0]  count_q;
	logic [STEP_W-1:0] steps_q;

	logic [IDX_W-1:0]  head_d, tail_d, iter_pos_d;
	logic [CAP_W-1:0]  count_d;
	logic [STEP_W-1:0] steps_d;
	logic [31:0]       data_d;
	logic [1:0]        status_d;
	logic              wr_en;
	logic [CAP_W-1:0]  eff_cap;
	logic [IDX_W-1:0]  rd_addr;

	// Clamp capacity to 1..DEPTH
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CAP_W'(1);
		end else if (32'(capacity) > DEPTH) begin
			eff_cap = CAP_W'(DEPTH);
		end else begin
			eff_cap = capacity;
		end
	end

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
			input logic [CAP_W-1:0] cap);
		logic [31:0] nxt;
		nxt = 32'(idx) + 32'd1;
		if (nxt >= 32'(cap)) begin
			return '0;
		end
		return nxt[IDX_W-1:0];
	endfunction

	assign rd_addr = (item.operation == cqi_pkg::OP_POP) ? head_q : iter_pos_q;

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		iter_pos_d = iter_pos_q;
		count_d    = count_q;
		steps_d    = steps_q;
		data_d     = '0;
		status_d   = cqi_pkg::ST_OK;
		wr_en      = 1'b0;
		case (op_q)
			cqi_pkg::OP_PUSH: begin
				if (count_q < eff_cap) begin
					if (count_q == '0) begin
						head_d = tail_q;
					end
					wr_en   = 1'b1;
					tail_d  = advance(tail_q, eff_cap);
					count_d = count_q + CAP_W'(1);
				end else begin
					status_d = cqi_pkg::ST_FULL;
				end
			end
			cqi_pkg::OP_POP: begin
				if (count_q != '0) begin
					data_d  = rd_data_q;
					count_d = count_q - CAP_W'(1);
					if (count_d == '0) begin
						head_d = '0;
						tail_d = '0;
					end else begin
						head_d = advance(head_q, eff_cap);
					end
				end else begin
					status_d = cqi_pkg::ST_EMPTY;
				end
			end
			cqi_pkg::OP_ITER_RST: begin
				iter_pos_d = head_q;
				steps_d    = '0;
			end
			default: begin
				if (steps_q >= count_q) begin
					status_d = cqi_pkg::ST_OUT_RANGE;
				end
				data_d     = rd_data_q;
				iter_pos_d = advance(iter_pos_q, eff_cap);
				if (steps_q < STEP_MAX) begin
					steps_d = steps_q + STEP_W'(1);
				end
			end
		endcase
	end

	// Store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.execute && wr_en) begin
			mem[tail_q] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= item.operation;
			val_q <= item.push_value;
		end
		if (cmd.execute) begin
			result.data_out      <= data_d;
			result.status        <= status_d;
			result.occupancy     <= count_d;
			result.iter_in_range <= (32'(steps_d) < 32'(count_d));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			iter_pos_q <= '0;
			count_q    <= '0;
			steps_q    <= '0;
		end else if (cmd.execute) begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			iter_pos_q <= iter_pos_d;
			count_q    <= count_d;
			steps_q    <= steps_d;
		end
	end

endmodule

// File: rtl/circular_queue_with_iterator.sv
// ----------------------------------------------------------------------------
// circular_queue_with_iterator: ring-buffer FIFO of 32-bit words with iterator
// Push, pop, iterator reset and iterator read-and-advance on one command port.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. busy then stays high for
//   one cycle while the operation executes.
//   Result channel: done pulses for exactly one cycle with result valid. The
//   receiver cannot stall; take the result in that cycle or lose it.
//   Result timing: the accepted operation is executed in the S_EXEC state,
//   and result and done are registered as the controller leaves S_EXEC.
//   Issue: no new operation is taken while busy is high. The ring store
//   has a single registered read port, so each operation first reads the
//   store in the capture step and then updates pointers and writes in the
//   execute step.
//   Configuration: APB register at address 0 holds capacity (5 bits, reset
//   16); write it only while idle. Zero acts as one, values above DEPTH act
//   as DEPTH.
//   Reset: arst_n clears pointers, count and iterator and returns capacity
//   to 16 at once. The store contents are undefined until written; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_queue_with_iterator #(
	parameter int unsigned DEPTH = cqi_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                start,
	output logic                busy,
	input  cqi_pkg::item_t      item,
	// result channel
	output logic                done,
	output cqi_pkg::result_t    result,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [cqi_pkg::CAP_W-1:0] capacity_q;
	cqi_pkg::dp_cmd_t          cmd;
	logic                      reg_hit;

	// Decode the register index from the word address
	assign reg_hit = (paddr[2:2] == cqi_pkg::REG_CAPACITY) && (paddr[1:0] == 2'b00);
	assign pready  = 1'b1;

	// Capture capacity on the access phase of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cqi_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			capacity_q <= pwdata[cqi_pkg::CAP_W-1:0];
		end
	end

	// Read back the register; unmapped addresses return zero
	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = 32'(capacity_q);
		end
	end

	cqi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cqi_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.capacity (capacity_q),
		.result   (result)
	);

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for circular_queue_with_iterator
// Issues queue and iterator commands over the start/busy channel, predicts
// each result with a local ring model, and checks every done pulse field by
// field. Capacity is reprogrammed over APB between phases, including the
// out-of-range settings and changes made while the queue still holds data.
// ----------------------------------------------------------------------------
module tb;

	import cqi_pkg::*;

	localparam int unsigned DEPTH       = DEPTH_DEF;
	localparam int unsigned IDX_W       = $clog2(DEPTH);
	localparam int unsigned STEPS_MAX   = 31;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned PHASE_OPS   = 150;
	localparam int unsigned PHASES      = 12;
	localparam logic [2:0]  CAP_ADDR    = {REG_CAPACITY, 2'b00};

	// Capacity per random phase; 0 and values above DEPTH are the clamped extremes.
	// The entry of 5'd0 in slot 10 is replaced by a random setting.
	localparam logic [4:0] PHASE_CAPS [PHASES] = '{
		5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd17, 5'd5, 5'd15, 5'd3, 5'd8, 5'd0, 5'd16
	};

	// Ring state as the block should hold it; written marks slots that hold data.
	typedef struct packed {
		logic [DEPTH-1:0][31:0] words;
		logic [DEPTH-1:0]       written;
		logic [4:0]             head;
		logic [4:0]             tail;
		logic [4:0]             count;
		logic [4:0]             ipos;
		logic [4:0]             steps;
		logic [4:0]             cap;
	} ring_t;

	typedef struct packed {
		logic  drain;  // hold this command until all results are in
		item_t cmd;
	} queued_op_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ring_t       ring_live;    // advanced as commands transfer into the block
	ring_t       ring_plan;    // advanced as commands are generated
	queued_op_t  queued_ops [$];
	result_t     pending_results [$];
	bit          took;
	int unsigned gap_left;
	int unsigned burst_left;
	int unsigned mismatches;
	int unsigned cycles;

	circular_queue_with_iterator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Ring model
	// ------------------------------------------------------------------

	// Zero behaves as one slot, anything above DEPTH as DEPTH.
	function automatic logic [4:0] eff_capacity(input logic [4:0] cap);
		if (cap == 5'd0)
			return 5'd1;
		if (cap > 5'(DEPTH))
			return 5'(DEPTH);
		return cap;
	endfunction

	// Wrap to slot zero once the index reaches the current capacity.
	function automatic logic [4:0] step_index(input logic [4:0] idx, input logic [4:0] lim);
		logic [4:0] nxt;
		nxt = idx + 5'd1;
		return (nxt >= lim) ? 5'd0 : nxt;
	endfunction

	function automatic result_t predict_queue_op(inout ring_t r, input item_t cmd);
		result_t    res;
		logic [4:0] lim;
		res = '0;
		res.status = ST_OK;
		lim = eff_capacity(r.cap);
		case (cmd.operation)
			OP_PUSH: begin
				if (r.count < lim) begin
					if (r.count == 5'd0)
						r.head = r.tail;
					r.words[r.tail[IDX_W-1:0]] = cmd.push_value;
					r.written[r.tail[IDX_W-1:0]] = 1'b1;
					r.tail = step_index(r.tail, lim);
					r.count = r.count + 5'd1;
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_POP: begin
				if (r.count != 5'd0) begin
					res.data_out = r.words[r.head[IDX_W-1:0]];
					r.count = r.count - 5'd1;
					// an emptied queue restarts at slot zero
					if (r.count == 5'd0) begin
						r.head = 5'd0;
						r.tail = 5'd0;
					end else begin
						r.head = step_index(r.head, lim);
					end
				end else begin
					res.status = ST_EMPTY;
				end
			end
			OP_ITER_RST: begin
				r.ipos = r.head;
				r.steps = 5'd0;
			end
			default: begin
				// read and advance even when past the stored words
				if (r.steps >= r.count)
					res.status = ST_OUT_RANGE;
				res.data_out = r.words[r.ipos[IDX_W-1:0]];
				r.ipos = step_index(r.ipos, lim);
				if (r.steps < 5'(STEPS_MAX))
					r.steps = r.steps + 5'd1;
			end
		endcase
		res.occupancy = r.count;
		res.iter_in_range = (r.steps < r.count);
		return res;
	endfunction

	// The store is undefined until written: never let a command read such a slot.
	function automatic bit reads_unwritten(input ring_t r, input item_t cmd);
		if (cmd.operation == OP_POP)
			return (r.count != 5'd0) && !r.written[r.head[IDX_W-1:0]];
		if (cmd.operation == OP_ITER_READ)
			return !r.written[r.ipos[IDX_W-1:0]];
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	function automatic void queue_cmd(input logic [1:0] op, input logic [31:0] value,
			input bit drain);
		queued_op_t q;
		q.drain = drain;
		q.cmd.operation = op;
		q.cmd.push_value = value;
		// swap an illegal read for a harmless command
		if (reads_unwritten(ring_plan, q.cmd))
			q.cmd.operation = (op == OP_POP) ? OP_PUSH : OP_ITER_RST;
		void'(predict_queue_op(ring_plan, q.cmd));
		queued_ops.insert(queued_ops.size(), q);
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Build one phase out of short segments: fill, drain, iterator walks and noise.
	function automatic void queue_random_phase(input int unsigned total);
		int unsigned left;
		int unsigned kind;
		int unsigned len;
		int unsigned pick;
		logic [1:0]  op;
		left = total;
		while (left > 0) begin
			kind = $urandom_range(0, 4);
			len = $urandom_range(3, 24);
			// long walks push the step count into saturation
			if (kind == 2 && $urandom_range(0, 3) == 0)
				len = $urandom_range(33, 40);
			for (int unsigned i = 0; i < len && left > 0; i++) begin
				pick = $urandom_range(0, 99);
				case (kind)
					0: op = (pick < 80) ? OP_PUSH : (pick < 90) ? OP_POP : 2'($urandom);
					1: op = (pick < 80) ? OP_POP : (pick < 90) ? OP_PUSH : 2'($urandom);
					2: begin
						if (i == 0)
							op = OP_ITER_RST;
						else
							op = (pick < 90) ? OP_ITER_READ : (pick < 95) ? OP_POP : OP_PUSH;
					end
					3: op = (pick < 50) ? OP_ITER_READ : (pick < 75) ? OP_PUSH : OP_POP;
					default: op = 2'($urandom);
				endcase
				queue_cmd(op, random_word(), $urandom_range(0, 149) == 0);
				left--;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------

	task automatic apb_transfer(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CAP_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold until nothing is queued, in flight or outstanding.
	task automatic wait_idle();
		while (queued_ops.size() != 0 || start || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] cap);
		logic [31:0] rd;
		wait_idle();
		apb_transfer(1'b1, 32'(cap), rd);
		ring_live.cap = cap;
		ring_plan.cap = cap;
		apb_transfer(1'b0, 32'h0, rd);
		if (rd !== 32'(cap)) begin
			$error("capacity readback: expected 0x%08h, got 0x%08h", 32'(cap), rd);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: present queued commands at the falling edge
	// ------------------------------------------------------------------

	function automatic int unsigned next_gap();
		int unsigned pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			// back-to-back stretch
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(negedge clk) begin
		if (arst_n && !(start && !took)) begin
			// start is low, or the previous command just transferred
			if (took)
				gap_left = next_gap();
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (queued_ops.size() != 0 &&
					!(queued_ops[0].drain && pending_results.size() != 0)) begin
				item  <= queued_ops[0].cmd;
				start <= 1'b1;
				queued_ops.delete(0);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check results, then record new transfers
	// ------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no command outstanding");
			mismatches++;
		end else begin
			want = pending_results[0];
			pending_results.delete(0);
			compare_field("data_out", want.data_out, got.data_out);
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
			compare_field("iter_in_range", 32'(want.iter_in_range), 32'(got.iter_in_range));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			took = 1'b0;
		end else begin
			if (done)
				check_result(result);
			took = start && !busy;
			if (took)
				pending_results.insert(pending_results.size(),
					predict_queue_op(ring_live, item));
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("circular_queue_with_iterator regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		took       = 1'b0;
		gap_left   = 0;
		burst_left = 0;
		mismatches = 0;
		cycles     = 0;
		ring_live  = '0;
		ring_live.cap = CAP_RESET;
		ring_plan  = ring_live;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on a four-slot ring: empty pop, field extremes, push
		// into a full ring, a full iterator walk that runs out of range, the
		// pop that empties and rewinds to slot zero.
		set_capacity(5'd4);
		queue_cmd(OP_POP, 32'h0, 1'b0);
		queue_cmd(OP_ITER_RST, 32'hffff_ffff, 1'b0);
		queue_cmd(OP_PUSH, 32'h8000_0000, 1'b0);
		queue_cmd(OP_PUSH, 32'h7fff_ffff, 1'b0);
		queue_cmd(OP_PUSH, 32'hffff_ffff, 1'b0);
		queue_cmd(OP_PUSH, 32'h0000_0000, 1'b0);
		queue_cmd(OP_PUSH, 32'h1234_5678, 1'b0);
		queue_cmd(OP_ITER_RST, 32'h0, 1'b0);
		repeat (5)
			queue_cmd(OP_ITER_READ, 32'h0, 1'b0);
		queue_cmd(OP_POP, 32'h0, 1'b1);
		repeat (3)
			queue_cmd(OP_POP, 32'h0, 1'b0);
		queue_cmd(OP_POP, 32'h0, 1'b0);
		queue_cmd(OP_PUSH, 32'h5555_5555, 1'b0);
		queue_cmd(OP_PUSH, 32'haaaa_aaaa, 1'b0);
		queue_cmd(OP_ITER_RST, 32'h0, 1'b0);
		queue_cmd(OP_ITER_READ, 32'h0, 1'b0);
		queue_cmd(OP_POP, 32'h0, 1'b0);
		queue_cmd(OP_POP, 32'h0, 1'b0);

		// Random phases; the queue keeps its contents across capacity changes.
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			set_capacity((ph == 10) ? 5'($urandom_range(0, 31)) : PHASE_CAPS[ph]);
			queue_random_phase(PHASE_OPS);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("circular_queue_with_iterator regression: pass");
		else
			$display("circular_queue_with_iterator regression: fail");
		$finish;
	end

endmodule
